### hdl/soi_pkg.sv
`default_nettype none

package soi_pkg;

    // Service table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_IW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TBL_CW      = $clog2(TABLE_DEPTH + 1);

    // Frame geometry.
    localparam logic [5:0] ETH_LEN  = 6'd14;
    localparam logic [5:0] HDR_LEN  = 6'd34;
    localparam logic [5:0] OPT_FRAME_LEN = 6'd42;
    localparam logic [5:0] POS_ETH_LAST  = 6'd13;
    localparam logic [5:0] POS_HDR_LAST  = 6'd33;

    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  OPT_TYPE     = 8'h1e;
    localparam logic [7:0]  OPT_LEN_BYTE = 8'h06;
    localparam logic [7:0]  OPT_TAIL     = 8'h01;
    localparam logic [3:0]  IHL_PLAIN    = 4'd5;
    localparam logic [3:0]  IHL_OPT      = 4'd7;
    localparam logic [15:0] LEN_GROWTH   = 16'd8;
    // Sum of the constant option words 0x1e06 and 0x0101.
    localparam logic [19:0] ACC_INIT     = 20'h01f07;

    // Opcodes.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    // Verdicts.
    localparam logic [1:0] V_PASS  = 2'd0;
    localparam logic [1:0] V_OPT   = 2'd1;
    localparam logic [1:0] V_ABORT = 2'd2;

    // Frame modes.
    localparam logic [1:0] M_HDR  = 2'd0;
    localparam logic [1:0] M_PASS = 2'd1;
    localparam logic [1:0] M_OPT  = 2'd2;
    localparam logic [1:0] M_DROP = 2'd3;

    typedef struct packed {
        logic       cap;
        logic       pos_clr;
        logic       scan_start;
        logic       scan_src_hdr;
        logic       scan_step;
        logic       tbl_add;
        logic       tbl_del;
        logic       clr_step;
        logic       ck_add;
        logic       ck_fold;
        logic       em_start;
        logic [5:0] em_len;
        logic       em_opt;
        logic [1:0] em_ver;
        logic       em_end;
        logic       em_rd;
        logic       em_load;
        logic       out_direct;
        logic [1:0] direct_ver;
        logic       out_status;
    } soi_cmd_t;

    typedef struct packed {
        logic at_eth;
        logic at_hdr;
        logic eth_ip;
        logic ihl5;
        logic scan_done;
        logic scan_found;
        logic scan_free;
        logic clr_done;
        logic em_done;
        logic out_free;
    } soi_status_t;

endpackage

`default_nettype wire

### hdl/soi_dpath.sv
`default_nettype none

module soi_dpath
    import soi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire soi_cmd_t    cmd,
    output soi_status_t      st,
    input  wire logic [7:0]  packet_byte,
    input  wire logic        frame_end,
    input  wire logic [31:0] service_address,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic [1:0]       verdict
);

    // Header buffer and service table memories.
    logic [7:0]  hb_mem [0:33];
    logic [32:0] tbl_mem [0:TABLE_DEPTH-1];

    logic [5:0]  pos_reg, pos_next, pos_eff;
    logic [19:0] acc_reg, acc_next, term;
    logic [7:0]  b12_reg, b14_reg;
    logic [15:0] tl_reg, tl_new;
    logic [31:0] dst_reg;
    logic [15:0] chk_reg;
    logic [16:0] fold1, fold2;
    logic [7:0]  hb_rd_reg;

    logic [31:0]       scan_key_reg;
    logic [TBL_CW-1:0] scan_idx_reg;
    logic              rd_vld_reg;
    logic [32:0]       tbl_rd_reg;
    logic              found_reg, free_reg;
    logic [TBL_IW-1:0] match_idx_reg, free_idx_reg, clr_idx_reg;
    logic              scan_issue;

    logic [5:0] em_idx_reg, em_len_reg;
    logic       em_opt_reg, em_end_reg;
    logic [1:0] em_ver_reg;
    logic [7:0] em_byte;
    logic       em_done;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] verdict_reg;
    logic       out_free, out_load;

    assign pos_eff    = (pos_reg >= HDR_LEN) ? 6'd0 : pos_reg;
    assign tl_new     = tl_reg + LEN_GROWTH;
    assign scan_issue = cmd.scan_step && (scan_idx_reg != TBL_CW'(TABLE_DEPTH));

    // Checksum contribution of the incoming header byte. The destination
    // address counts twice, once more for its copy in the option.
    always_comb
    begin
        case (pos_eff) inside
            6'd14:     term = {4'h0, packet_byte[7:4], IHL_OPT, 8'h00};
            [6'd16:6'd17], [6'd24:6'd25]: term = 20'd0;
            [6'd30:6'd33]: term = pos_eff[0] ? {11'd0, packet_byte, 1'b0}
                                             : {3'd0, packet_byte, 9'd0};
            [6'd15:6'd29]: term = pos_eff[0] ? {12'd0, packet_byte}
                                             : {4'd0, packet_byte, 8'd0};
            default:   term = 20'd0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (cmd.cap)
        begin
            pos_next = pos_eff + 6'd1;
            acc_next = acc_reg + term;
        end
        if (cmd.ck_add)
            acc_next = acc_reg + {4'd0, tl_new};
        if (cmd.pos_clr)
        begin
            pos_next = 6'd0;
            acc_next = ACC_INIT;
        end
    end

    assign fold1 = {1'b0, acc_reg[15:0]} + {13'd0, acc_reg[19:16]};
    assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            hb_mem[pos_eff] <= packet_byte;
            case (pos_eff)
                6'd12: b12_reg <= packet_byte;
                6'd14: b14_reg <= packet_byte;
                6'd16: tl_reg[15:8] <= packet_byte;
                6'd17: tl_reg[7:0] <= packet_byte;
                6'd30: dst_reg[31:24] <= packet_byte;
                6'd31: dst_reg[23:16] <= packet_byte;
                6'd32: dst_reg[15:8] <= packet_byte;
                6'd33: dst_reg[7:0] <= packet_byte;
                default: ;
            endcase
        end
        if (cmd.em_rd && (em_idx_reg < HDR_LEN))
            hb_rd_reg <= hb_mem[em_idx_reg];
        if (cmd.ck_fold)
            chk_reg <= ~fold2[15:0];
    end

    // Service table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            tbl_mem[clr_idx_reg] <= 33'd0;
        else if (cmd.tbl_add)
            tbl_mem[free_idx_reg] <= {1'b1, scan_key_reg};
        else if (cmd.tbl_del)
            tbl_mem[match_idx_reg] <= {1'b0, scan_key_reg};
        if (scan_issue)
            tbl_rd_reg <= tbl_mem[scan_idx_reg[TBL_IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
            scan_key_reg <= cmd.scan_src_hdr ? {dst_reg[31:8], packet_byte} : service_address;
        if (rd_vld_reg && tbl_rd_reg[32] && (tbl_rd_reg[31:0] == scan_key_reg) && !found_reg)
            match_idx_reg <= scan_idx_reg[TBL_IW-1:0] - TBL_IW'(1);
        if (rd_vld_reg && !tbl_rd_reg[32] && !free_reg)
            free_idx_reg <= scan_idx_reg[TBL_IW-1:0] - TBL_IW'(1);
        if (cmd.em_start)
        begin
            em_len_reg <= cmd.em_len;
            em_opt_reg <= cmd.em_opt;
            em_ver_reg <= cmd.em_ver;
            em_end_reg <= cmd.em_end;
        end
        if (out_load)
        begin
            if (cmd.em_load)
            begin
                out_byte_reg <= em_byte;
                out_last_reg <= em_end_reg && em_done;
                verdict_reg  <= em_ver_reg;
            end
            else if (cmd.out_direct)
            begin
                out_byte_reg <= packet_byte;
                out_last_reg <= frame_end;
                verdict_reg  <= cmd.direct_ver;
            end
            else
            begin
                out_byte_reg <= 8'd0;
                out_last_reg <= 1'b1;
                verdict_reg  <= V_ABORT;
            end
        end
    end

    // The index of a returning read is one behind the issue counter, so
    // the captured index above subtracts one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 6'd0;
            acc_reg       <= ACC_INIT;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            em_idx_reg    <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            if (cmd.clr_step)
                clr_idx_reg <= clr_idx_reg + TBL_IW'(1);
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg <= scan_issue;
                if (scan_issue)
                    scan_idx_reg <= scan_idx_reg + TBL_CW'(1);
                if (rd_vld_reg && tbl_rd_reg[32] && (tbl_rd_reg[31:0] == scan_key_reg))
                    found_reg <= 1'b1;
                if (rd_vld_reg && !tbl_rd_reg[32])
                    free_reg <= 1'b1;
            end
            if (cmd.em_start)
                em_idx_reg <= 6'd0;
            else if (cmd.em_load)
                em_idx_reg <= em_idx_reg + 6'd1;
            out_valid_reg <= out_load || (out_valid_reg && !out_ready);
        end
    end

    always_comb
    begin
        em_byte = hb_rd_reg;
        if (em_opt_reg)
        begin
            case (em_idx_reg)
                6'd14: em_byte = {b14_reg[7:4], IHL_OPT};
                6'd16: em_byte = tl_new[15:8];
                6'd17: em_byte = tl_new[7:0];
                6'd24: em_byte = chk_reg[15:8];
                6'd25: em_byte = chk_reg[7:0];
                6'd34: em_byte = OPT_TYPE;
                6'd35: em_byte = OPT_LEN_BYTE;
                6'd36: em_byte = dst_reg[31:24];
                6'd37: em_byte = dst_reg[23:16];
                6'd38: em_byte = dst_reg[15:8];
                6'd39: em_byte = dst_reg[7:0];
                6'd40: em_byte = OPT_TAIL;
                6'd41: em_byte = OPT_TAIL;
                default: em_byte = hb_rd_reg;
            endcase
        end
    end

    assign em_done  = (em_idx_reg == (em_len_reg - 6'd1));
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = cmd.em_load || cmd.out_direct || cmd.out_status;

    assign st.at_eth     = (pos_eff == POS_ETH_LAST);
    assign st.at_hdr     = (pos_eff == POS_HDR_LAST);
    assign st.eth_ip     = ({b12_reg, packet_byte} == ETYPE_IPV4);
    assign st.ihl5       = (b14_reg[3:0] == IHL_PLAIN);
    assign st.scan_done  = (scan_idx_reg == TBL_CW'(TABLE_DEPTH)) && !rd_vld_reg;
    assign st.scan_found = found_reg;
    assign st.scan_free  = free_reg;
    assign st.clr_done   = (clr_idx_reg == TBL_IW'(TABLE_DEPTH - 1));
    assign st.em_done    = em_done;
    assign st.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign verdict   = verdict_reg;

endmodule

`default_nettype wire

### hdl/soi_ctrl.sv
`default_nettype none

module soi_ctrl
    import soi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic        frame_end,
    input  wire soi_status_t st,
    output soi_cmd_t         cmd
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CK    = 3'd3;
    localparam logic [2:0] S_FOLD  = 3'd4;
    localparam logic [2:0] S_EM_RD = 3'd5;
    localparam logic [2:0] S_EM_LD = 3'd6;
    localparam logic [2:0] S_ABORT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] op_reg, op_next;
    logic       end_reg, end_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && st.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        mode_next  = mode_reg;
        op_next    = op_reg;
        end_next   = end_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode) inside
                        OP_ADD, OP_DEL:
                        begin
                            cmd.scan_start = 1'b1;
                            op_next        = opcode;
                            state_next     = S_SCAN;
                        end
                        OP_BYTE:
                        begin
                            case (mode_reg) inside
                                M_PASS, M_OPT:
                                begin
                                    cmd.out_direct = 1'b1;
                                    cmd.direct_ver = (mode_reg == M_OPT) ? V_OPT : V_PASS;
                                    if (frame_end)
                                    begin
                                        cmd.pos_clr = 1'b1;
                                        mode_next   = M_HDR;
                                    end
                                end
                                M_DROP:
                                begin
                                    if (frame_end)
                                    begin
                                        cmd.out_status = 1'b1;
                                        cmd.pos_clr    = 1'b1;
                                        mode_next      = M_HDR;
                                    end
                                end
                                default:
                                begin
                                    cmd.cap = 1'b1;
                                    if (st.at_eth && !st.eth_ip)
                                    begin
                                        cmd.em_start = 1'b1;
                                        cmd.em_len   = ETH_LEN;
                                        cmd.em_ver   = V_PASS;
                                        cmd.em_end   = frame_end;
                                        if (frame_end)
                                            cmd.pos_clr = 1'b1;
                                        else
                                            mode_next = M_PASS;
                                        state_next = S_EM_RD;
                                    end
                                    else if (st.at_hdr)
                                    begin
                                        cmd.scan_start   = 1'b1;
                                        cmd.scan_src_hdr = 1'b1;
                                        op_next          = OP_BYTE;
                                        end_next         = frame_end;
                                        state_next       = S_SCAN;
                                    end
                                    else if (frame_end)
                                    begin
                                        cmd.out_status = 1'b1;
                                        cmd.pos_clr    = 1'b1;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (st.scan_done)
                begin
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ADD:
                            cmd.tbl_add = !st.scan_found && st.scan_free;
                        OP_DEL:
                            cmd.tbl_del = st.scan_found;
                        default:
                        begin
                            if (!st.scan_found)
                            begin
                                cmd.em_start = 1'b1;
                                cmd.em_len   = HDR_LEN;
                                cmd.em_ver   = V_PASS;
                                cmd.em_end   = end_reg;
                                if (end_reg)
                                    cmd.pos_clr = 1'b1;
                                else
                                    mode_next = M_PASS;
                                state_next = S_EM_RD;
                            end
                            else if (!st.ihl5)
                            begin
                                if (end_reg)
                                begin
                                    cmd.pos_clr = 1'b1;
                                    state_next  = S_ABORT;
                                end
                                else
                                    mode_next = M_DROP;
                            end
                            else
                                state_next = S_CK;
                        end
                    endcase
                end
            end
            S_CK:
            begin
                cmd.ck_add = 1'b1;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.ck_fold  = 1'b1;
                cmd.em_start = 1'b1;
                cmd.em_len   = OPT_FRAME_LEN;
                cmd.em_opt   = 1'b1;
                cmd.em_ver   = V_OPT;
                cmd.em_end   = end_reg;
                if (end_reg)
                    cmd.pos_clr = 1'b1;
                else
                    mode_next = M_OPT;
                state_next = S_EM_RD;
            end
            S_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = S_EM_LD;
            end
            S_EM_LD:
            begin
                if (st.out_free)
                begin
                    cmd.em_load = 1'b1;
                    state_next  = st.em_done ? S_IDLE : S_EM_RD;
                end
            end
            S_ABORT:
            begin
                if (st.out_free)
                begin
                    cmd.out_status = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            mode_reg  <= M_HDR;
            op_reg    <= OP_BYTE;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            end_reg   <= end_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ipv4_service_option_inserter_unit.sv
// Channel | Handshake           | Beat payload
// in      | in_valid / in_ready | opcode, packet_byte, frame_end, service_address
// out     | out_valid/out_ready | out_byte, out_last, verdict
//
// A pass-through byte or an ordinary header byte is handled without leaving
// the idle state. Table operations and the destination lookup scan the whole
// table, one entry a cycle through a single read port. A header release
// reads each byte from the buffer, then loads it into the output register,
// with checksum work (S_CK, then S_FOLD) first when the option is inserted.
// After reset a clearing pass empties the table; no beat is taken in that
// time. Output stalls hold the block where it is.
`default_nettype none

module ipv4_service_option_inserter_unit
    import soi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  packet_byte,
    input  wire logic        frame_end,
    input  wire logic [31:0] service_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic [1:0]       verdict
);

    // The controller sequences each beat; the datapath holds the header
    // buffer, the service table, the checksum accumulator and the output
    // register.
    soi_cmd_t    cmd;
    soi_status_t st;

    soi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .frame_end (frame_end),
        .st        (st),
        .cmd       (cmd)
    );

    soi_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .packet_byte     (packet_byte),
        .frame_end       (frame_end),
        .service_address (service_address),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .verdict         (verdict)
    );

endmodule

`default_nettype wire
